// ===== hdl/ipr_pkg.sv =====
`default_nettype none
package ipr_pkg;

  // Field and register widths
  localparam int PIX_W        = 8;
  localparam int ADDR_W       = 27;
  localparam int CFG_DIM_W    = 11;
  localparam int CFG_SCALE_W  = 4;
  localparam int STRIDE_W     = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE = 3'd4;

  // Operands of the shared multiply-add unit: a * b + c
  typedef struct packed {
    logic [ADDR_W-1:0]   a;
    logic [STRIDE_W-1:0] b;
    logic [ADDR_W-1:0]   c;
  } mac_op_t;

endpackage
`default_nettype wire

// ===== hdl/ipr_pixel_if.sv =====
`default_nettype none
interface ipr_pixel_if;
  import ipr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/ipr_write_if.sv =====
`default_nettype none
interface ipr_write_if;
  import ipr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dst_address;
  logic [PIX_W-1:0]  pixel_out;
  logic              run_last;
  logic              image_done;

  modport source (output valid, output dst_address, output pixel_out,
                  output run_last, output image_done, input ready);
  modport sink   (input valid, input dst_address, input pixel_out,
                  input run_last, input image_done, output ready);
endinterface
`default_nettype wire

// ===== hdl/ipr_mac.sv =====
`default_nettype none
module ipr_mac (
  input  ipr_pkg::mac_op_t             op,
  output logic [ipr_pkg::ADDR_W-1:0]   result
);
  import ipr_pkg::*;

  logic [ADDR_W+STRIDE_W-1:0] prod;

  // One multiply and one add, truncated to the address width
  always_comb begin
    prod   = (ADDR_W+STRIDE_W)'(op.a) * (ADDR_W+STRIDE_W)'(op.b);
    result = prod[ADDR_W-1:0] + op.c;
  end
endmodule
`default_nettype wire

// ===== hdl/integer_pixel_replication_upscaler_core.sv =====
`default_nettype none
// Nearest-neighbor integer upscaler. Each source pixel, taken in raster order,
// becomes scale_y x scale_x writes of the same value, rows outer and columns
// inner, at address (row*scale_y+v)*dst_stride + col*scale_x+u modulo 2^27.
// One shared multiply-add unit first builds the base address in the states
// S_ROW, S_COL and S_BASE, then steps the address once per write; a pixel
// with a zero scale factor is taken but produces nothing.
// The input is not ready while a pixel is being expanded. Scale factors above
// MAX_SCALE saturate; a zero width or height counts as 1. Register writes
// must happen while the block is idle and do not reset the position counters.
module integer_pixel_replication_upscaler_core #(
  parameter int MAX_SRC_DIM = 1024,
  parameter int MAX_SCALE   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]   cfg_data,
  ipr_pixel_if.sink                        pixels,
  ipr_write_if.source                      writes
);
  import ipr_pkg::*;

  localparam int POS_W = $clog2(MAX_SRC_DIM);
  localparam int DIM_W = (CFG_DIM_W > POS_W + 1) ? CFG_DIM_W : POS_W + 1;
  localparam int SC_W  = $clog2(MAX_SCALE + 1);
  localparam logic [DIM_W-1:0]       MAX_DIM_V   = DIM_W'(MAX_SRC_DIM);
  localparam logic [CFG_SCALE_W-1:0] MAX_SCALE_V = CFG_SCALE_W'(MAX_SCALE);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROW  = 5'b00010,
    S_COL  = 5'b00100,
    S_BASE = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // Configuration registers
  logic [CFG_DIM_W-1:0]   src_width;
  logic [CFG_DIM_W-1:0]   src_height;
  logic [CFG_SCALE_W-1:0] scale_x;
  logic [CFG_SCALE_W-1:0] scale_y;
  logic [STRIDE_W-1:0]    dst_stride;

  // Position and sequencer state
  state_t             state;
  state_t             state_next;
  logic [POS_W-1:0]   src_col;
  logic [POS_W-1:0]   src_row;
  logic [POS_W-1:0]   col_l;
  logic [POS_W-1:0]   row_l;
  logic [PIX_W-1:0]   pix;
  logic [SC_W-1:0]    sx;
  logic [SC_W-1:0]    sy;
  logic [SC_W-1:0]    u;
  logic [SC_W-1:0]    v;
  logic               img_last;
  logic [ADDR_W-1:0]  rs;
  logic [ADDR_W-1:0]  cs;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  row_base;

  logic [DIM_W-1:0]   w_c;
  logic [DIM_W-1:0]   h_c;
  logic [SC_W-1:0]    sx_c;
  logic [SC_W-1:0]    sy_c;
  logic               last_col;
  logic               last_row;
  logic               in_acc;
  logic               out_acc;
  logic               u_end;
  logic               v_end;
  mac_op_t            op;
  logic [ADDR_W-1:0]  mac_res;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= CFG_DIM_W'(1);
      src_height <= CFG_DIM_W'(1);
      scale_x    <= CFG_SCALE_W'(1);
      scale_y    <= CFG_SCALE_W'(1);
      dst_stride <= STRIDE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[CFG_DIM_W-1:0];
        REG_SCALE_X:    scale_x    <= cfg_data[CFG_SCALE_W-1:0];
        REG_SCALE_Y:    scale_y    <= cfg_data[CFG_SCALE_W-1:0];
        REG_DST_STRIDE: dst_stride <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and end-of-line flags
  always_comb begin
    if (src_width == '0)                    w_c = DIM_W'(1);
    else if (DIM_W'(src_width) > MAX_DIM_V) w_c = MAX_DIM_V;
    else                                    w_c = DIM_W'(src_width);
    if (src_height == '0)                    h_c = DIM_W'(1);
    else if (DIM_W'(src_height) > MAX_DIM_V) h_c = MAX_DIM_V;
    else                                     h_c = DIM_W'(src_height);
    sx_c = (scale_x > MAX_SCALE_V) ? SC_W'(MAX_SCALE) : SC_W'(scale_x);
    sy_c = (scale_y > MAX_SCALE_V) ? SC_W'(MAX_SCALE) : SC_W'(scale_y);
    last_col = (DIM_W'(src_col) + DIM_W'(1)) >= w_c;
    last_row = (DIM_W'(src_row) + DIM_W'(1)) >= h_c;
  end

  assign pixels.ready = (state == S_IDLE);
  assign in_acc       = pixels.valid && pixels.ready;
  assign writes.valid = (state == S_EMIT);
  assign out_acc      = writes.valid && writes.ready;
  assign u_end        = (u == sx - SC_W'(1));
  assign v_end        = (v == sy - SC_W'(1));

  // Source position counters advance on every accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        src_col <= '0;
        src_row <= last_row ? '0 : src_row + POS_W'(1);
      end else begin
        src_col <= src_col + POS_W'(1);
      end
    end
  end

  // Operand select for the shared unit
  always_comb begin
    op = '0;
    case (state)
      S_ROW: begin
        op.a = ADDR_W'(row_l);
        op.b = STRIDE_W'(sy);
      end
      S_COL: begin
        op.a = ADDR_W'(col_l);
        op.b = STRIDE_W'(sx);
      end
      S_BASE: begin
        op.a = rs;
        op.b = dst_stride;
        op.c = cs;
      end
      S_EMIT: begin
        op.a = ADDR_W'(1);
        if (u_end) begin
          op.b = dst_stride;
          op.c = row_base;
        end else begin
          op.b = STRIDE_W'(1);
          op.c = addr;
        end
      end
      default: op = '0;
    endcase
  end

  ipr_mac u_mac (
    .op     (op),
    .result (mac_res)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && sx_c != '0 && sy_c != '0) state_next = S_ROW;
      S_ROW:  state_next = S_COL;
      S_COL:  state_next = S_BASE;
      S_BASE: state_next = S_EMIT;
      S_EMIT: if (out_acc && u_end && v_end) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          pix      <= pixels.pixel_in;
          col_l    <= src_col;
          row_l    <= src_row;
          sx       <= sx_c;
          sy       <= sy_c;
          img_last <= last_col && last_row;
        end
      end
      S_ROW: rs <= mac_res;
      S_COL: cs <= mac_res;
      S_BASE: begin
        addr     <= mac_res;
        row_base <= mac_res;
        u        <= '0;
        v        <= '0;
      end
      S_EMIT: begin
        if (out_acc && !(u_end && v_end)) begin
          addr <= mac_res;
          if (u_end) begin
            row_base <= mac_res;
            u        <= '0;
            v        <= v + SC_W'(1);
          end else begin
            u <= u + SC_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign writes.dst_address = addr;
  assign writes.pixel_out   = pix;
  assign writes.run_last    = u_end && v_end;
  assign writes.image_done  = u_end && v_end && img_last;

endmodule
`default_nettype wire

// ===== hdl/ipr_checker.sv =====
`default_nettype none
module ipr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ipr_pkg::ADDR_W-1:0]    dst_address,
  input wire logic [ipr_pkg::PIX_W-1:0]     pixel_out,
  input wire logic                          run_last,
  input wire logic                          image_done
);
  // Input is never taken while a write is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid)
    else $error("pixel accepted while write pending");

  // End of image only on the last write of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> run_last)
    else $error("image_done without run_last");

  // The run ends after its last word is taken
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && run_last) |=> !out_valid)
    else $error("write after end of run");

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(dst_address) && $stable(pixel_out)))
    else $error("stalled word changed");
endmodule

bind integer_pixel_replication_upscaler_core ipr_checker u_ipr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixels.valid),
  .in_ready    (pixels.ready),
  .out_valid   (writes.valid),
  .out_ready   (writes.ready),
  .dst_address (writes.dst_address),
  .pixel_out   (writes.pixel_out),
  .run_last    (writes.run_last),
  .image_done  (writes.image_done)
);
`default_nettype wire
